// ----- hw/rtl/hrlp_pkg.sv -----
package hrlp_pkg;

    // Parser state, one-hot
    typedef enum logic [9:0] {
        ST_WAIT_METHOD   = 10'b00_0000_0001,
        ST_METHOD        = 10'b00_0000_0010,
        ST_AFTER_METHOD  = 10'b00_0000_0100,
        ST_URI           = 10'b00_0000_1000,
        ST_AFTER_URI     = 10'b00_0001_0000,
        ST_VERSION       = 10'b00_0010_0000,
        ST_AFTER_VERSION = 10'b00_0100_0000,
        ST_CR_SEEN       = 10'b00_1000_0000,
        ST_DONE          = 10'b01_0000_0000,
        ST_ERROR         = 10'b10_0000_0000
    } t_state;

    // Parse state codes as seen on the result port
    localparam logic [3:0] PS_WAIT_METHOD   = 4'd0;
    localparam logic [3:0] PS_METHOD        = 4'd1;
    localparam logic [3:0] PS_AFTER_METHOD  = 4'd2;
    localparam logic [3:0] PS_URI           = 4'd3;
    localparam logic [3:0] PS_AFTER_URI     = 4'd4;
    localparam logic [3:0] PS_VERSION       = 4'd5;
    localparam logic [3:0] PS_AFTER_VERSION = 4'd6;
    localparam logic [3:0] PS_CR_SEEN       = 4'd7;
    localparam logic [3:0] PS_DONE          = 4'd8;
    localparam logic [3:0] PS_ERROR         = 4'd9;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_METHOD_S = 3'd1,
        EV_METHOD_E = 3'd2,
        EV_URI_S    = 3'd3,
        EV_URI_E    = 3'd4,
        EV_VER_S    = 3'd5,
        EV_VER_E    = 3'd6
    } t_event;

    localparam logic [1:0] VER_0_9  = 2'd0;
    localparam logic [1:0] VER_1_0  = 2'd1;
    localparam logic [1:0] VER_1_1  = 2'd2;
    localparam logic [1:0] VER_NONE = 2'd3;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_H     = 8'h48;

    localparam int unsigned VER_LEN = 8;

    localparam logic [63:0] VER_TEXT_0_9 = "HTTP/0.9";
    localparam logic [63:0] VER_TEXT_1_0 = "HTTP/1.0";
    localparam logic [63:0] VER_TEXT_1_1 = "HTTP/1.1";

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_upper(c) || ((c >= 8'h61) && (c <= 8'h7A))
            || ((c >= 8'h30) && (c <= 8'h39));
    endfunction

    // Character idx (first character is 0) of version string v
    function automatic logic [7:0] ver_char(input logic [1:0] v, input logic [2:0] idx);
        logic [63:0] text;
        case (v)
            VER_0_9: text = VER_TEXT_0_9;
            VER_1_0: text = VER_TEXT_1_0;
            default: text = VER_TEXT_1_1;
        endcase
        return text[8 * (7 - int'(idx)) +: 8];
    endfunction

    function automatic logic [3:0] state_code(input t_state s);
        case (s)
            ST_WAIT_METHOD:   return PS_WAIT_METHOD;
            ST_METHOD:        return PS_METHOD;
            ST_AFTER_METHOD:  return PS_AFTER_METHOD;
            ST_URI:           return PS_URI;
            ST_AFTER_URI:     return PS_AFTER_URI;
            ST_VERSION:       return PS_VERSION;
            ST_AFTER_VERSION: return PS_AFTER_VERSION;
            ST_CR_SEEN:       return PS_CR_SEEN;
            ST_DONE:          return PS_DONE;
            default:          return PS_ERROR;
        endcase
    endfunction

endpackage

// ----- hw/rtl/http_request_line_parser_core.sv -----
// HTTP request line parser. One byte per transaction on the input channel,
// one result per byte on the output channel. A byte passes an input
// register, then a combinational state update writes the result register
// once the output is free, so a stall holds the byte in the input register.
// The block sustains one byte per cycle while the output is not stalled,
// the parser state feeding back into its own update. The input register
// lets a new byte be taken while a result still waits on a stalled output.
// i_start_line restarts parsing at byte offset zero; after done or error,
// bytes leave the state unchanged. POS_WIDTH sets the byte offset counter,
// which saturates at its maximum; reported offsets saturate at 65535.
module http_request_line_parser_core #(
    parameter int POS_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_start_line,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_parse_state,
    output logic [2:0]  o_boundary_event,
    output logic [15:0] o_boundary_offset,
    output logic [1:0]  o_version_code
);
    import hrlp_pkg::*;

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    // input register
    logic                 r_in_valid;
    logic                 r_in_start;
    logic [7:0]           r_in_byte;

    // parser state
    t_state               r_state;
    logic [POS_WIDTH-1:0] r_pos;
    logic [2:0]           r_mask;
    logic [3:0]           r_len;
    logic [1:0]           r_ver;

    // result register
    logic                 r_out_valid;
    logic [3:0]           r_parse_state;
    logic [2:0]           r_event;
    logic [15:0]          r_offset;
    logic [1:0]           r_version;

    logic                 advance;

    t_state               cur_state;
    logic [POS_WIDTH-1:0] cur_pos;
    logic [2:0]           cur_mask;
    logic [3:0]           cur_len;
    logic [1:0]           cur_ver;
    logic [POS_WIDTH-1:0] end_pos;
    logic [2:0]           take_mask;
    logic [3:0]           take_len;
    logic [1:0]           fin_ver;

    t_state               n_state;
    logic [POS_WIDTH-1:0] n_pos;
    logic [2:0]           n_mask;
    logic [3:0]           n_len;
    logic [1:0]           n_ver;
    t_event               n_event;
    logic [POS_WIDTH-1:0] n_off;
    logic [31:0]          off_wide;
    logic [15:0]          n_offset;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        // a restart clears the state before this byte is parsed
        cur_state = r_in_start ? ST_WAIT_METHOD : r_state;
        cur_pos   = r_in_start ? '0 : r_pos;
        cur_mask  = r_in_start ? 3'b111 : r_mask;
        cur_len   = r_in_start ? 4'd0 : r_len;
        cur_ver   = r_in_start ? VER_NONE : r_ver;

        end_pos = (cur_pos != '0) ? cur_pos - 1'b1 : '0;

        for (int i = 0; i < 3; i++) begin
            take_mask[i] = cur_mask[i] && !cur_len[3]
                && (ver_char(2'(i), cur_len[2:0]) == r_in_byte);
        end
        take_len = (cur_len != 4'hF) ? cur_len + 4'd1 : cur_len;

        fin_ver = VER_NONE;
        if (cur_len == 4'(VER_LEN)) begin
            if (cur_mask[0]) begin
                fin_ver = VER_0_9;
            end else if (cur_mask[1]) begin
                fin_ver = VER_1_0;
            end else if (cur_mask[2]) begin
                fin_ver = VER_1_1;
            end
        end

        n_state = cur_state;
        n_pos   = cur_pos;
        n_mask  = cur_mask;
        n_len   = cur_len;
        n_ver   = cur_ver;
        n_event = EV_NONE;
        n_off   = '0;

        if (cur_state != ST_DONE && cur_state != ST_ERROR) begin
            case (cur_state)
                ST_WAIT_METHOD: begin
                    if (r_in_byte == CH_SP || r_in_byte == CH_CR || r_in_byte == CH_LF) begin
                        n_state = cur_state;
                    end else if (is_upper(r_in_byte)) begin
                        n_state = ST_METHOD;
                        n_event = EV_METHOD_S;
                        n_off   = cur_pos;
                    end else begin
                        n_state = ST_ERROR;
                    end
                end
                ST_METHOD: begin
                    if (is_upper(r_in_byte)) begin
                        n_state = cur_state;
                    end else if (r_in_byte == CH_SP) begin
                        n_state = ST_AFTER_METHOD;
                        n_event = EV_METHOD_E;
                        n_off   = end_pos;
                    end else begin
                        n_state = ST_ERROR;
                    end
                end
                ST_AFTER_METHOD: begin
                    if (r_in_byte == CH_SLASH) begin
                        n_state = ST_URI;
                        n_event = EV_URI_S;
                        n_off   = cur_pos;
                    end else if (r_in_byte != CH_SP) begin
                        n_state = ST_ERROR;
                    end
                end
                ST_URI: begin
                    if (r_in_byte == CH_SP || r_in_byte == CH_CR) begin
                        n_state = (r_in_byte == CH_SP) ? ST_AFTER_URI : ST_CR_SEEN;
                        n_event = EV_URI_E;
                        n_off   = end_pos;
                    end
                end
                ST_AFTER_URI: begin
                    if (r_in_byte == CH_SP) begin
                        n_state = cur_state;
                    end else if (r_in_byte == CH_CR) begin
                        n_state = ST_CR_SEEN;
                    end else if (r_in_byte == CH_H) begin
                        // 'H' matches the first character of every candidate
                        n_state = ST_VERSION;
                        n_event = EV_VER_S;
                        n_off   = cur_pos;
                        n_mask  = 3'b111;
                        n_len   = 4'd1;
                    end else begin
                        n_state = ST_ERROR;
                    end
                end
                ST_VERSION: begin
                    if (is_alnum(r_in_byte) || r_in_byte == CH_SLASH
                            || r_in_byte == CH_DOT) begin
                        n_mask = take_mask;
                        n_len  = take_len;
                    end else if (r_in_byte == CH_SP || r_in_byte == CH_CR) begin
                        n_event = EV_VER_E;
                        n_off   = end_pos;
                        if (fin_ver != VER_NONE) begin
                            n_ver   = fin_ver;
                            n_state = (r_in_byte == CH_SP) ? ST_AFTER_VERSION : ST_CR_SEEN;
                        end else begin
                            n_state = ST_ERROR;
                        end
                    end else begin
                        n_state = ST_ERROR;
                    end
                end
                ST_AFTER_VERSION: begin
                    if (r_in_byte == CH_SP) begin
                        n_state = cur_state;
                    end else if (r_in_byte == CH_CR) begin
                        n_state = ST_CR_SEEN;
                    end else begin
                        n_state = ST_ERROR;
                    end
                end
                ST_CR_SEEN: begin
                    n_state = (r_in_byte == CH_LF) ? ST_DONE : ST_ERROR;
                end
                default: begin
                    n_state = ST_ERROR;
                end
            endcase
            n_pos = (cur_pos != POS_MAX) ? cur_pos + 1'b1 : cur_pos;
        end

        off_wide = 32'(n_off);
        n_offset = (off_wide > 32'h0000_FFFF) ? 16'hFFFF : off_wide[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_WAIT_METHOD;
            r_pos       <= '0;
            r_mask      <= 3'b111;
            r_len       <= 4'd0;
            r_ver       <= VER_NONE;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_pos       <= n_pos;
                r_mask      <= n_mask;
                r_len       <= n_len;
                r_ver       <= n_ver;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_start <= i_start_line;
            r_in_byte  <= i_data_byte;
        end
        if (advance) begin
            r_parse_state <= state_code(n_state);
            r_event       <= n_event;
            r_offset      <= n_offset;
            r_version     <= n_ver;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_parse_state     = r_parse_state;
    assign o_boundary_event  = r_event;
    assign o_boundary_offset = r_offset;
    assign o_version_code    = r_version;

endmodule

// ----- hw/rtl/hrlp_checker.sv -----
module hrlp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  o_parse_state,
    input logic [2:0]  o_boundary_event,
    input logic [15:0] o_boundary_offset,
    input logic [1:0]  o_version_code
);
    import hrlp_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_parse_state) && $stable(o_boundary_event)
            && $stable(o_boundary_offset) && $stable(o_version_code))
        else $error("result changed while stalled");

    a_no_event_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_boundary_event == EV_NONE |-> o_boundary_offset == 16'd0)
        else $error("offset without boundary event");

    // a matched version only exists once the version token has closed
    a_version_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_version_code != VER_NONE |->
            o_parse_state == PS_AFTER_VERSION || o_parse_state == PS_CR_SEEN
            || o_parse_state == PS_DONE || o_parse_state == PS_ERROR)
        else $error("version code reported before version end");

    a_version_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_boundary_event == EV_VER_E && o_parse_state != PS_ERROR
            |-> o_version_code != VER_NONE)
        else $error("version end accepted without a match");

    a_method_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_boundary_event == EV_METHOD_S |-> o_parse_state == PS_METHOD)
        else $error("method start outside method state");

endmodule

bind http_request_line_parser_core hrlp_checker u_hrlp_checker (.*);

// ----- tb/http_request_line_parser_checker.sv -----
`timescale 1ns / 1ps

module http_request_line_parser_checker #(
    parameter int POS_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_start_line,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  i_parse_state,
    input  logic [2:0]  i_boundary_event,
    input  logic [15:0] i_boundary_offset,
    input  logic [1:0]  i_version_code,
    output int          o_errors,
    output int          o_pending
);
    import hrlp_pkg::*;

    typedef struct packed {
        logic [3:0]  state;
        logic [2:0]  boundary;
        logic [15:0] offset;
        logic [1:0]  version;
    } parse_result_t;

    localparam logic [POS_WIDTH-1:0] POS_LIMIT = '1;

    logic [3:0]           line_state;
    logic [POS_WIDTH-1:0] line_pos;
    logic [2:0]           ver_mask;
    logic [3:0]           ver_len;
    logic [1:0]           ver_found;
    parse_result_t        expected_results[$];
    int                   error_count = 0;

    assign o_errors = error_count;

    function automatic logic upper_letter(input logic [7:0] c);
        return c >= 8'h41 && c <= 8'h5A;
    endfunction

    function automatic logic token_char(input logic [7:0] c);
        return upper_letter(c) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39)
            || c == CH_SLASH || c == CH_DOT;
    endfunction

    function automatic logic [7:0] version_char(input int v, input logic [2:0] k);
        case (v)
            0:       return VER_TEXT_0_9[8 * (7 - int'(k)) +: 8];
            1:       return VER_TEXT_1_0[8 * (7 - int'(k)) +: 8];
            default: return VER_TEXT_1_1[8 * (7 - int'(k)) +: 8];
        endcase
    endfunction

    task automatic clear_parser();
        line_state = PS_WAIT_METHOD;
        line_pos   = '0;
        ver_mask   = 3'b111;
        ver_len    = 4'd0;
        ver_found  = VER_NONE;
    endtask

    // drop every candidate string that disagrees at this position
    task automatic take_version_char(input logic [7:0] c);
        for (int v = 0; v < 3; v++) begin
            if (ver_len >= VER_LEN || version_char(v, ver_len[2:0]) != c) begin
                ver_mask[v] = 1'b0;
            end
        end
        if (ver_len != 4'd15) begin
            ver_len++;
        end
    endtask

    function automatic logic [1:0] finished_version();
        if (ver_len != VER_LEN) return VER_NONE;
        if (ver_mask[0]) return VER_0_9;
        if (ver_mask[1]) return VER_1_0;
        if (ver_mask[2]) return VER_1_1;
        return VER_NONE;
    endfunction

    task automatic parse_byte(input logic restart, input logic [7:0] c,
                              output parse_result_t res);
        logic [3:0]  nxt;
        t_event      mark;
        logic [31:0] here;
        logic [31:0] prev;
        logic [31:0] off;
        logic [1:0]  found;
        if (restart) begin
            clear_parser();
        end
        nxt  = line_state;
        here = 32'(line_pos);
        prev = (here != 0) ? here - 1 : 0;
        mark = EV_NONE;
        off  = 0;
        if (line_state != PS_DONE && line_state != PS_ERROR) begin
            case (line_state)
                PS_WAIT_METHOD: begin
                    if (c == CH_SP || c == CH_CR || c == CH_LF) begin
                        nxt = PS_WAIT_METHOD;
                    end else if (upper_letter(c)) begin
                        nxt = PS_METHOD; mark = EV_METHOD_S; off = here;
                    end else begin
                        nxt = PS_ERROR;
                    end
                end
                PS_METHOD: begin
                    if (c == CH_SP) begin
                        nxt = PS_AFTER_METHOD; mark = EV_METHOD_E; off = prev;
                    end else if (!upper_letter(c)) begin
                        nxt = PS_ERROR;
                    end
                end
                PS_AFTER_METHOD: begin
                    if (c == CH_SLASH) begin
                        nxt = PS_URI; mark = EV_URI_S; off = here;
                    end else if (c != CH_SP) begin
                        nxt = PS_ERROR;
                    end
                end
                PS_URI: begin
                    if (c == CH_SP || c == CH_CR) begin
                        nxt  = (c == CH_SP) ? PS_AFTER_URI : PS_CR_SEEN;
                        mark = EV_URI_E;
                        off  = prev;
                    end
                end
                PS_AFTER_URI: begin
                    if (c == CH_CR) begin
                        nxt = PS_CR_SEEN;
                    end else if (c == CH_H) begin
                        nxt = PS_VERSION; mark = EV_VER_S; off = here;
                        ver_mask = 3'b111;
                        ver_len  = 4'd0;
                        take_version_char(c);
                    end else if (c != CH_SP) begin
                        nxt = PS_ERROR;
                    end
                end
                PS_VERSION: begin
                    if (token_char(c)) begin
                        take_version_char(c);
                    end else if (c == CH_SP || c == CH_CR) begin
                        found = finished_version();
                        mark  = EV_VER_E;
                        off   = prev;
                        if (found != VER_NONE) begin
                            ver_found = found;
                            nxt = (c == CH_SP) ? PS_AFTER_VERSION : PS_CR_SEEN;
                        end else begin
                            nxt = PS_ERROR;
                        end
                    end else begin
                        nxt = PS_ERROR;
                    end
                end
                PS_AFTER_VERSION: begin
                    if (c == CH_CR) begin
                        nxt = PS_CR_SEEN;
                    end else if (c != CH_SP) begin
                        nxt = PS_ERROR;
                    end
                end
                PS_CR_SEEN: begin
                    nxt = (c == CH_LF) ? PS_DONE : PS_ERROR;
                end
                default: begin
                    nxt = PS_ERROR;
                end
            endcase
            line_state = nxt;
            if (line_pos != POS_LIMIT) begin
                line_pos++;
            end
        end
        if (mark == EV_NONE) off = 0;
        if (off > 32'hFFFF) off = 32'hFFFF;
        res.state    = line_state;
        res.boundary = mark;
        res.offset   = off[15:0];
        res.version  = ver_found;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        parse_result_t want;
        if (!i_rst_n) begin
            clear_parser();
            expected_results.delete();
            o_pending <= 0;
        end else begin
            // retire before predicting so a result can never match its own byte
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no byte outstanding");
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("parse_state", 16'(want.state), 16'(i_parse_state));
                    compare_field("boundary_event", 16'(want.boundary),
                                  16'(i_boundary_event));
                    compare_field("boundary_offset", want.offset, i_boundary_offset);
                    compare_field("version_code", 16'(want.version), 16'(i_version_code));
                end
            end
            if (i_in_valid && i_in_ready) begin
                parse_byte(i_start_line, i_data_byte, want);
                expected_results.push_back(want);
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

// ----- tb/tb_http_request_line_parser_core.sv -----
`timescale 1ns / 1ps

module tb_http_request_line_parser_core;
    import hrlp_pkg::*;

    localparam int POS_WIDTH    = 16;
    localparam int STALL_LIMIT  = 1000;
    localparam int BYTE_TARGET  = 1750;
    localparam int TAIL_BYTES   = 300;
    localparam int LONG_URI_LEN = 150;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        i_start_line = 1'b0;
    logic [7:0]  i_data_byte  = 8'h00;
    logic        i_out_ready  = 1'b1;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [3:0]  o_parse_state;
    logic [2:0]  o_boundary_event;
    logic [15:0] o_boundary_offset;
    logic [1:0]  o_version_code;

    int         errors;
    int         pending;
    int         stall_cycles = 0;
    int         sink_hold    = 0;
    logic       idle_on      = 1'b0;
    logic [7:0] line_buf[$];
    int         sent_bytes   = 0;
    int         line_count   = 0;

    http_request_line_parser_core #(
        .POS_WIDTH(POS_WIDTH)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_start_line     (i_start_line),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_parse_state    (o_parse_state),
        .o_boundary_event (o_boundary_event),
        .o_boundary_offset(o_boundary_offset),
        .o_version_code   (o_version_code)
    );

    http_request_line_parser_checker #(
        .POS_WIDTH(POS_WIDTH)
    ) parse_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_start_line     (i_start_line),
        .i_data_byte      (i_data_byte),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_parse_state    (o_parse_state),
        .i_boundary_event (o_boundary_event),
        .i_boundary_offset(o_boundary_offset),
        .i_version_code   (o_version_code),
        .o_errors         (errors),
        .o_pending        (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result sink: stall in random bursts, started only while idling is on
    always @(posedge i_clk) begin
        if (sink_hold != 0) begin
            sink_hold   <= sink_hold - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
            sink_hold   <= $urandom_range(0, 7);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("tb_http_request_line_parser_core: done, errors");
        $finish;
    end

    task automatic send_byte(input logic restart, input logic [7:0] b);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_start_line <= restart;
        i_data_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sent_bytes++;
    endtask

    // hold off the sender until every outstanding result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic send_line(input logic restart);
        for (int k = 0; k < line_buf.size(); k++) begin
            send_byte(restart && k == 0, line_buf[k]);
        end
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            line_buf.push_back(s[k]);
        end
    endtask

    function automatic string version_string(input int v);
        case (v)
            0:       return "HTTP/0.9";
            1:       return "HTTP/1.0";
            default: return "HTTP/1.1";
        endcase
    endfunction

    function automatic logic [7:0] pick_token_char();
        case ($urandom_range(0, 4))
            0:       return 8'($urandom_range(8'h41, 8'h5A));
            1:       return 8'($urandom_range(8'h61, 8'h7A));
            2:       return 8'($urandom_range(8'h30, 8'h39));
            3:       return CH_SLASH;
            default: return CH_DOT;
        endcase
    endfunction

    function automatic logic [7:0] pick_uri_char();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0) return CH_LF;
        do c = 8'($urandom_range(0, 255)); while (c == CH_SP || c == CH_CR);
        return c;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 2))
            0:       return CH_SP;
            1:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // mostly well-formed lines with random content, some damaged or pure noise
    task automatic build_request_line();
        string      vtext;
        int         mode;
        int         spot;
        int         cut;
        logic [7:0] c;
        line_buf.delete();
        if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) line_buf.push_back(pick_blank());
        repeat ($urandom_range(1, 7)) line_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
        repeat ($urandom_range(1, 3)) line_buf.push_back(CH_SP);
        line_buf.push_back(CH_SLASH);
        repeat ($urandom_range(0, 10)) line_buf.push_back(pick_uri_char());
        case ($urandom_range(0, 5))
            0: line_buf.push_back(CH_CR);
            1: begin
                repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SP);
                line_buf.push_back(CH_CR);
            end
            default: begin
                repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SP);
                vtext = version_string($urandom_range(0, 2));
                mode  = $urandom_range(0, 9);
                spot  = $urandom_range(1, 7);
                cut   = $urandom_range(1, 7);
                for (int k = 0; k < 8; k++) begin
                    c = vtext[k];
                    if (mode == 6 && k >= cut) break;
                    if (mode == 8 && k == spot) c = pick_token_char();
                    if (mode == 9 && k == spot) c = 8'($urandom_range(0, 255));
                    line_buf.push_back(c);
                end
                // overlong token, sometimes past the length counter's ceiling
                if (mode == 7) begin
                    repeat ($urandom_range(1, 10)) line_buf.push_back(pick_token_char());
                end
                if ($urandom_range(0, 1) == 0) begin
                    repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SP);
                end
                line_buf.push_back(CH_CR);
            end
        endcase
        line_buf.push_back(CH_LF);
        if ($urandom_range(0, 5) == 0) begin
            line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, line_buf.size() - 1)) void'(line_buf.pop_back());
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bytes before any restart: invalid first byte, then one that is ignored
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h00);
        // shortest complete line, led by a blank
        line_buf.delete();
        add_text("\nZ /\r\n");
        send_line(1'b1);
        // LF inside the URI, version, trailing space
        line_buf.delete();
        add_text("A /\n HTTP/1.0 \r\n");
        send_line(1'b1);
        send_byte(1'b1, 8'h00);
        drain();

        while (sent_bytes < BYTE_TARGET - TAIL_BYTES) begin
            idle_on <= ($urandom_range(0, 3) != 0);
            build_request_line();
            send_line($urandom_range(0, 19) != 0);
            // junk after the line end, normally ignored
            repeat ($urandom_range(0, 2)) send_byte(1'b0, 8'($urandom_range(0, 255)));
            line_count++;
            if (line_count % 100 == 0) drain();
        end

        // tail with no idling: a longer URI, then lines back to back
        idle_on <= 1'b0;
        drain();
        line_buf.delete();
        add_text("GET /");
        repeat (LONG_URI_LEN) line_buf.push_back(pick_uri_char());
        add_text(" HTTP/1.1\r\n");
        send_line(1'b1);
        send_byte(1'b0, 8'h41);
        repeat (6) begin
            build_request_line();
            send_line(1'b1);
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb_http_request_line_parser_core: done, clean");
        end else begin
            $display("tb_http_request_line_parser_core: done, errors");
        end
        $finish;
    end

endmodule
